// ===== design/lcsle_pkg.sv =====
package lcsle_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int FUNC_W          = 2;
   localparam int SYM_W           = 8;
   localparam int LEN_W           = 7;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SYM_W-1:0]  symbol;
   } req_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0] lcs_length;
      logic [LEN_W-1:0] first_length;
      logic             overflow_dropped;
      logic             order_dropped;
   } rsp_payload_type;

   // operations that travel down the cell row
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SCAN   = 2'd1,
      OP_FINISH = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      cell_op_type      op;
      logic [SYM_W-1:0] symbol;
      logic             overflow_seen;
      logic             order_seen;
   } cell_ctrl_type;

endpackage

// ===== design/lcsle_cell.sv =====
module lcsle_cell
   import lcsle_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  cell_ctrl_type       in_ctrl,
   input  logic [CNT_W-1:0]    in_idx,
   input  logic [CNT_W-1:0]    in_diag,
   input  logic [CNT_W-1:0]    in_left,
   output cell_ctrl_type       out_ctrl,
   output logic [CNT_W-1:0]    out_idx,
   output logic [CNT_W-1:0]    out_diag,
   output logic [CNT_W-1:0]    out_left
);

   localparam logic [CNT_W-1:0] INDEX_C = CNT_W'(INDEX);

   logic             loaded_ff, loaded_in;
   logic [SYM_W-1:0] byte_ff, byte_in;
   logic [CNT_W-1:0] row_ff, row_in;
   cell_ctrl_type    ctrl_ff, ctrl_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] diag_ff, diag_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] new_value;

   // dp recurrence for this column
   always_comb begin
      if (byte_ff == in_ctrl.symbol) begin
         new_value = in_diag + CNT_W'(1);
      end else if (row_ff > in_left) begin
         new_value = row_ff;
      end else begin
         new_value = in_left;
      end
   end

   always_comb begin
      loaded_in = loaded_ff;
      byte_in   = byte_ff;
      row_in    = row_ff;
      ctrl_in   = in_ctrl;
      idx_in    = in_idx;
      diag_in   = in_diag;
      left_in   = in_left;
      if (in_ctrl.valid) begin
         unique case (in_ctrl.op)
            OP_LOAD: begin
               if (in_idx == INDEX_C) begin
                  loaded_in = 1'b1;
                  byte_in   = in_ctrl.symbol;
               end
            end
            OP_SCAN: begin
               diag_in = row_ff;
               left_in = new_value;
               row_in  = new_value;
            end
            OP_FINISH: begin
               // last loaded cell leaves its value as the answer
               if (loaded_ff) begin
                  left_in = row_ff;
               end
               loaded_in = 1'b0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // loaded flag, dp value and only the valid bit of the beat register get a reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= 1'b0;
         row_ff        <= '0;
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         loaded_ff <= loaded_in;
         row_ff    <= row_in;
         ctrl_ff   <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         idx_ff  <= idx_in;
         diag_ff <= diag_in;
         left_ff <= left_in;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_idx  = idx_ff;
   assign out_diag = diag_ff;
   assign out_left = left_ff;

endmodule

// ===== design/lcs_length_engine_unit.sv =====
// Longest common subsequence length engine. Beats on req_ carry a function
// code and a byte: append appends the byte to the first string (at most
// MAX_LEN bytes), scan feeds one byte of the second string, finish returns
// one rsp_ beat with the LCS length, the kept first-string length and two
// drop flags, and starts a fresh comparison. Appends past capacity, and
// appends after the first scan, are dropped and flagged; function code 3 is
// ignored. The block is a row of MAX_LEN cells, one per first-string byte,
// each holding its byte and its dp value; every request travels down the row
// one cell per cycle, so scans run as a skewed wavefront. One request beat is
// taken every cycle while the row advances; a finish beat passes through every
// cell register and then the response register before it shows up on rsp_. The
// row only stalls while a response is waiting and rsp_ready is low. No clearing
// pass is needed after reset or between comparisons: the finish beat clears
// each cell as it passes.
module lcs_length_engine_unit
   import lcsle_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);

   // front-end bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic             second_ff, second_in;
   logic             overflow_ff, overflow_in;
   logic             order_ff, order_in;

   logic            advance;
   logic            req_take;
   cell_ctrl_type   inject_ctrl;
   logic [CNT_W-1:0] inject_idx;

   // row wiring, stage 0 is the injected beat
   cell_ctrl_type    chain_ctrl [0:MAX_LEN];
   logic [CNT_W-1:0] chain_idx  [0:MAX_LEN];
   logic [CNT_W-1:0] chain_diag [0:MAX_LEN];
   logic [CNT_W-1:0] chain_left [0:MAX_LEN];

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            tail_finish;

   // whole row moves unless a response is stuck in the output register
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_take  = req_valid && advance;

   // decode the request into a row beat and update the bookkeeping
   always_comb begin
      count_in    = count_ff;
      second_in   = second_ff;
      overflow_in = overflow_ff;
      order_in    = order_ff;

      inject_ctrl.valid         = 1'b0;
      inject_ctrl.op            = OP_LOAD;
      inject_ctrl.symbol        = req_data.symbol;
      inject_ctrl.overflow_seen = overflow_ff;
      inject_ctrl.order_seen    = order_ff;
      inject_idx                = count_ff;

      if (req_take) begin
         priority if (req_data.func == FUNC_APPEND) begin
            // ordering check wins over the capacity check
            priority if (second_ff) begin
               order_in = 1'b1;
            end else if (count_ff == MAX_LEN_C) begin
               overflow_in = 1'b1;
            end else begin
               inject_ctrl.valid = 1'b1;
               inject_ctrl.op    = OP_LOAD;
               count_in          = count_ff + CNT_W'(1);
            end
         end else if (req_data.func == FUNC_SCAN) begin
            inject_ctrl.valid = 1'b1;
            inject_ctrl.op    = OP_SCAN;
            second_in         = 1'b1;
         end else if (req_data.func == FUNC_FINISH) begin
            inject_ctrl.valid = 1'b1;
            inject_ctrl.op    = OP_FINISH;
            count_in          = '0;
            second_in         = 1'b0;
            overflow_in       = 1'b0;
            order_in          = 1'b0;
         end else begin
            // unused code, nothing happens
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         second_ff   <= 1'b0;
         overflow_ff <= 1'b0;
         order_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         second_ff   <= second_in;
         overflow_ff <= overflow_in;
         order_ff    <= order_in;
      end
   end

   assign chain_ctrl[0] = inject_ctrl;
   assign chain_idx[0]  = inject_idx;
   assign chain_diag[0] = '0;
   assign chain_left[0] = '0;

   // the cell row
   for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      lcsle_cell #(
         .INDEX (gi),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_ctrl  (chain_ctrl[gi]),
         .in_idx   (chain_idx[gi]),
         .in_diag  (chain_diag[gi]),
         .in_left  (chain_left[gi]),
         .out_ctrl (chain_ctrl[gi+1]),
         .out_idx  (chain_idx[gi+1]),
         .out_diag (chain_diag[gi+1]),
         .out_left (chain_left[gi+1])
      );
   end

   // only finish beats leaving the row become responses
   assign tail_finish = chain_ctrl[MAX_LEN].valid && (chain_ctrl[MAX_LEN].op == OP_FINISH);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in                 = tail_finish;
         rsp_data_in.lcs_length       = LEN_W'(chain_left[MAX_LEN]);
         rsp_data_in.first_length     = LEN_W'(chain_idx[MAX_LEN]);
         rsp_data_in.overflow_dropped = chain_ctrl[MAX_LEN].overflow_seen;
         rsp_data_in.order_dropped    = chain_ctrl[MAX_LEN].order_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/tb_lcs_length_engine_unit.sv =====
`timescale 1ns / 100ps

module tb_lcs_length_engine_unit;
   import lcsle_pkg::*;

   localparam int MAX_LEN      = MAX_LEN_DEFAULT;
   localparam int RANDOM_ITEMS = 1150;
   localparam int DIRECTED_ROWS = 24;

   // code 3 has no meaning in the block and must be dropped silently
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam rsp_payload_type NO_RESULT = '0;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   lcs_length_engine_unit #(
      .MAX_LEN (MAX_LEN)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // lcs predictor: first string kept in a byte array, one dp row over it
   // ------------------------------------------------------------------
   logic [SYM_W-1:0] kept_first [MAX_LEN];
   logic [LEN_W-1:0] lcs_row    [MAX_LEN];
   int               kept_count;
   bit               scan_started;
   bit               overflow_flag;
   bit               order_flag;

   rsp_payload_type  expected_results [$];

   // typed-in expectation travels with the beat on the directed rows
   bit               beat_typed        = 1'b0;
   rsp_payload_type  beat_typed_result = '0;

   int               mismatches     = 0;
   int               results_seen   = 0;
   int               capacity_drops = 0;
   int               order_drops    = 0;
   int               longest_lcs    = 0;
   int               request_beats  = 0;
   bit               quiet          = 1'b0;

   // returns 1 when the beat produces a result beat
   function automatic bit advance_comparison(input req_payload_type beat,
                                             output rsp_payload_type result);
      int diag;
      int left;
      int up;
      int next;
      int i;
      result = '0;
      case (beat.func)
         FUNC_APPEND: begin
            // order check wins over capacity check
            if (scan_started)
               order_flag = 1'b1;
            else if (kept_count >= MAX_LEN)
               overflow_flag = 1'b1;
            else begin
               kept_first[kept_count] = beat.symbol;
               kept_count++;
            end
            return 1'b0;
         end
         FUNC_SCAN: begin
            scan_started = 1'b1;
            diag = 0;
            left = 0;
            for (i = 0; i < kept_count; i++) begin
               up = int'(lcs_row[i]);
               if (kept_first[i] == beat.symbol)
                  next = diag + 1;
               else
                  next = (up > left) ? up : left;
               diag = up;
               lcs_row[i] = next[LEN_W-1:0];
               left = next;
            end
            return 1'b0;
         end
         FUNC_FINISH: begin
            result.lcs_length       = (kept_count > 0) ? lcs_row[kept_count-1] : '0;
            result.first_length     = kept_count[LEN_W-1:0];
            result.overflow_dropped = overflow_flag;
            result.order_dropped    = order_flag;
            // fresh comparison afterwards
            for (i = 0; i < MAX_LEN; i++)
               lcs_row[i] = '0;
            kept_count    = 0;
            scan_started  = 1'b0;
            overflow_flag = 1'b0;
            order_flag    = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic check_field(input string label, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: both channels sampled at the rising edge
   // ------------------------------------------------------------------
   rsp_payload_type predicted;
   rsp_payload_type oldest;

   initial begin
      for (int i = 0; i < MAX_LEN; i++)
         lcs_row[i] = '0;
      kept_count    = 0;
      scan_started  = 1'b0;
      overflow_flag = 1'b0;
      order_flag    = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         // request first so a same-edge push never hides behind a pop
         if (req_valid && req_ready) begin
            if (advance_comparison(req_data, predicted)) begin
               if (beat_typed)
                  expected_results.push_back(beat_typed_result);
               else
                  expected_results.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, lcs %0d first %0d",
                        $time, rsp_data.lcs_length, rsp_data.first_length);
               mismatches++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("lcs_length", oldest.lcs_length, rsp_data.lcs_length);
               check_field("first_length", oldest.first_length, rsp_data.first_length);
               check_field("overflow_dropped", LEN_W'(oldest.overflow_dropped),
                           LEN_W'(rsp_data.overflow_dropped));
               check_field("order_dropped", LEN_W'(oldest.order_dropped),
                           LEN_W'(rsp_data.order_dropped));
               results_seen++;
               if (oldest.overflow_dropped) capacity_drops++;
               if (oldest.order_dropped) order_drops++;
               if (int'(oldest.lcs_length) > longest_lcs)
                  longest_lcs = int'(oldest.lcs_length);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result side back-pressure: stall bursts, calm stretches, none at the end
   // ------------------------------------------------------------------
   int stall_left = 0;
   int calm_left  = 0;

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left != 0)
            calm_left <= calm_left - 1;
         else
            case ($urandom_range(0, 9))
               0, 1, 2: stall_left <= $urandom_range(1, 18);
               3:       calm_left  <= $urandom_range(20, 120);
               default: ;
            endcase
      end
   end

   // ------------------------------------------------------------------
   // request driver: one beat per call, changes only at the falling edge
   // ------------------------------------------------------------------
   int sender_calm = 0;

   task automatic drive_beat(input logic [FUNC_W-1:0] beat_func,
                             input logic [SYM_W-1:0] beat_symbol,
                             input bit typed, input rsp_payload_type typed_result);
      int gap;
      gap = 0;
      if (!quiet) begin
         if (sender_calm != 0)
            sender_calm--;
         else
            case ($urandom_range(0, 15))
               0, 1: gap = $urandom_range(1, 18);
               2:    sender_calm = $urandom_range(20, 120);
               default: ;
            endcase
      end
      // idle burst with valid low
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data          <= {beat_func, beat_symbol};
      beat_typed        <= typed;
      beat_typed_result <= typed_result;
      // hold until taken
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (beat_func != FUNC_UNUSED) request_beats++;
   endtask

   // stray unused-code beats sprinkled into the random part
   task automatic maybe_noise();
      if ($urandom_range(0, 39) == 0)
         drive_beat(FUNC_UNUSED, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
   endtask

   // one random comparison: appends, scans, a rare late append, finish
   task automatic run_comparison();
      int first_len;
      int second_len;
      int base;
      int span;
      int late_at;
      int i;
      case ($urandom_range(0, 19))
         0: begin
            // around capacity
            first_len  = $urandom_range(MAX_LEN - 4, MAX_LEN + 4);
            second_len = $urandom_range(0, MAX_LEN + 6);
         end
         1: begin
            first_len  = 0;
            second_len = $urandom_range(0, 8);
         end
         2: begin
            first_len  = $urandom_range(0, 8);
            second_len = 0;
         end
         default: begin
            first_len  = $urandom_range(1, 12);
            second_len = $urandom_range(1, 14);
         end
      endcase
      // narrow alphabet most of the time so matches are common
      base = $urandom_range(0, 255);
      span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 3);
      late_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, second_len)) : -1;

      for (i = 0; i < first_len; i++) begin
         maybe_noise();
         drive_beat(FUNC_APPEND, SYM_W'(base + $urandom_range(0, span)), 1'b0, NO_RESULT);
      end
      for (i = 0; i <= second_len; i++) begin
         maybe_noise();
         // broken sequence: first-string byte after scanning began
         if (i == late_at && i != 0)
            drive_beat(FUNC_APPEND, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
         if (i < second_len)
            drive_beat(FUNC_SCAN, SYM_W'(base + $urandom_range(0, span)), 1'b0, NO_RESULT);
      end
      drive_beat(FUNC_FINISH, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
   endtask

   // ------------------------------------------------------------------
   // directed table: result typed in only where it is obvious
   // ------------------------------------------------------------------
   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [SYM_W-1:0]  symbol;
      int                beats;
      bit                typed;
      rsp_payload_type   result;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // finish straight out of reset
      '{FUNC_FINISH, 8'h00, 1, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b0}},
      // unused code leaves nothing behind, finish ignores its byte
      '{FUNC_UNUSED, 8'hFF, 1, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'hFF, 1, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b0}},
      // empty second string
      '{FUNC_APPEND, 8'h00, 1, 1'b0, NO_RESULT},
      '{FUNC_APPEND, 8'hFF, 1, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'h00, 1, 1'b1, '{7'd0, 7'd2, 1'b0, 1'b0}},
      // empty first string
      '{FUNC_SCAN,   8'hAA, 1, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'h55, 1, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'h00, 1, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b0}},
      // small mixed case, unused code in the middle of the scans
      '{FUNC_APPEND, 8'h00, 1, 1'b0, NO_RESULT},
      '{FUNC_APPEND, 8'hFF, 1, 1'b0, NO_RESULT},
      '{FUNC_APPEND, 8'h5A, 1, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'hFF, 1, 1'b0, NO_RESULT},
      '{FUNC_UNUSED, 8'h00, 1, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'h00, 1, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'h5A, 1, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'h00, 1, 1'b0, NO_RESULT},
      // one byte past capacity, full-length match
      '{FUNC_APPEND, 8'h3C, MAX_LEN + 1, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'h3C, MAX_LEN, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'h00, 1, 1'b1, '{7'd64, 7'd64, 1'b1, 1'b0}},
      // full string, then late bytes: order flag only, no capacity flag
      '{FUNC_APPEND, 8'h81, MAX_LEN, 1'b0, NO_RESULT},
      '{FUNC_SCAN,   8'h81, 1, 1'b0, NO_RESULT},
      '{FUNC_APPEND, 8'h7E, 2, 1'b0, NO_RESULT},
      '{FUNC_FINISH, 8'h00, 1, 1'b1, '{7'd1, 7'd64, 1'b0, 1'b1}}
   };

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int random_start;
      int comparisons;
      comparisons = 0;

      // synchronous reset, released at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++)
         repeat (directed_rows[r].beats)
            drive_beat(directed_rows[r].func, directed_rows[r].symbol,
                       directed_rows[r].typed, directed_rows[r].result);

      // random comparisons, last part with no idling on either side
      random_start = request_beats;
      while (request_beats - random_start < RANDOM_ITEMS) begin
         if (request_beats - random_start >= RANDOM_ITEMS * 85 / 100)
            quiet = 1'b1;
         run_comparison();
         comparisons++;
      end
      req_valid <= 1'b0;

      // drain, then wait quietly for stray beats
      while (expected_results.size() != 0) @(posedge clock);
      repeat (MAX_LEN + 16) @(posedge clock);

      $display("run covered %0d request beats and %0d checked results (%0d random comparisons)",
               request_beats, results_seen, comparisons);
      $display("results with capacity drop %0d, with order drop %0d, longest lcs %0d",
               capacity_drops, order_drops, longest_lcs);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("timeout with %0d results still expected", expected_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
